[sv/kvfe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package kvfe_pkg;

    localparam int VALUE_BUFFER_LEN = 256;

    localparam logic KEY_SNI  = 1'b0;
    localparam logic KEY_HOST = 1'b1;

    localparam logic [2:0] SNI_KEY_LEN  = 3'd4;
    localparam logic [2:0] HOST_KEY_LEN = 3'd5;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_AMP = 8'h26;
    localparam logic [7:0] CH_HSH = 8'h23;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] LEN_MAX = 8'hFF;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic       key_id;
        logic       is_end_marker;
        logic [7:0] value_byte;
        logic       value_valid;
        logic [7:0] value_length;
        logic       last_of_run;
    } t_result;

    // up to two results caused by one input byte, sni slot first
    typedef struct packed {
        logic    v0;
        t_result r0;
        logic    v1;
        t_result r1;
    } t_entry;

    function automatic logic [7:0] key_char(input logic key, input logic [2:0] idx);
        logic [7:0] c;
        case ({key, idx})
            {KEY_SNI, 3'd0}:  c = 8'h73; // s
            {KEY_SNI, 3'd1}:  c = 8'h6E; // n
            {KEY_SNI, 3'd2}:  c = 8'h69; // i
            {KEY_SNI, 3'd3}:  c = 8'h3D; // =
            {KEY_HOST, 3'd0}: c = 8'h68; // h
            {KEY_HOST, 3'd1}: c = 8'h6F; // o
            {KEY_HOST, 3'd2}: c = 8'h73; // s
            {KEY_HOST, 3'd3}: c = 8'h74; // t
            {KEY_HOST, 3'd4}: c = 8'h3D; // =
            default:          c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic is_term(input logic [7:0] b);
        return (b == CH_NUL) || (b == CH_AMP) || (b == CH_HSH) ||
               (b == CH_CR) || (b == CH_LF) || (b == CH_SP);
    endfunction

    function automatic logic length_ok(input logic [7:0] len);
        return (len != 8'd0) && (len != LEN_MAX) && (32'(len) < (VALUE_BUFFER_LEN - 1));
    endfunction

endpackage

`default_nettype wire

[sv/kvfe_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module kvfe_front import kvfe_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_end_of_file,
    input  wire logic       i_q_full,
    output logic            o_q_push,
    output t_entry          o_q_entry
);

    typedef struct packed {
        logic [2:0] prog;
        logic       cap;
        logic [7:0] len;
    } t_key_state;

    typedef struct packed {
        t_key_state st;
        logic       emit;
        t_result    res;
    } t_key_step;

    function automatic t_key_step step_key(input logic key, input logic [2:0] klen,
                                           input t_key_state s, input logic [7:0] b,
                                           input logic eof);
        t_key_step  o;
        logic [2:0] p;
        logic [7:0] nlen;
        o = '0;
        o.st = s;
        o.res.key_id = key;
        if (s.cap) begin
            o.emit = 1'b1;
            if (is_term(b)) begin
                o.res.is_end_marker = 1'b1;
                o.res.value_valid   = length_ok(s.len);
                o.res.value_length  = s.len;
                o.st.cap = 1'b0;
                o.st.len = 8'd0;
            end else begin
                nlen = (s.len == LEN_MAX) ? s.len : s.len + 8'd1;
                o.st.len = nlen;
                o.res.value_byte    = b;
                o.res.value_length  = nlen;
                o.res.is_end_marker = eof;
                o.res.value_valid   = eof & length_ok(nlen);
            end
        end else begin
            p = (s.prog >= klen) ? 3'd0 : s.prog;
            if (b == key_char(key, p)) begin
                p = p + 3'd1;
            end else begin
                p = (b == key_char(key, 3'd0)) ? 3'd1 : 3'd0;
            end
            if (p == klen) begin
                o.st.prog = 3'd0;
                o.st.cap  = 1'b1;
                o.st.len  = 8'd0;
                // key completed on the final byte gives an empty end marker
                o.emit = eof;
                o.res.is_end_marker = 1'b1;
            end else begin
                o.st.prog = p;
            end
        end
        return o;
    endfunction

    t_key_state r_sni, n_sni, r_host, n_host;
    logic       r_stopped, n_stopped;
    t_key_step  w_s0, w_s1;
    logic       w_accept;

    assign o_in_ready = !i_q_full;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        w_s0 = step_key(KEY_SNI, SNI_KEY_LEN, r_sni, i_text_byte, i_end_of_file);
        w_s1 = step_key(KEY_HOST, HOST_KEY_LEN, r_host, i_text_byte, i_end_of_file);

        o_q_entry.v0 = !r_stopped && w_s0.emit;
        o_q_entry.v1 = !r_stopped && w_s1.emit;
        o_q_entry.r0 = w_s0.res;
        o_q_entry.r1 = w_s1.res;
        o_q_entry.r0.last_of_run = !o_q_entry.v1;
        o_q_entry.r1.last_of_run = 1'b1;
        o_q_push = w_accept && (o_q_entry.v0 || o_q_entry.v1);

        n_sni     = r_sni;
        n_host    = r_host;
        n_stopped = r_stopped;
        if (w_accept) begin
            if (i_end_of_file) begin
                n_sni     = '0;
                n_host    = '0;
                n_stopped = 1'b0;
            end else if (!r_stopped) begin
                if (i_text_byte == CH_NUL) begin
                    n_sni     = '0;
                    n_host    = '0;
                    n_stopped = 1'b1;
                end else begin
                    n_sni  = w_s0.st;
                    n_host = w_s1.st;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sni     <= '0;
            r_host    <= '0;
            r_stopped <= 1'b0;
        end else begin
            r_sni     <= n_sni;
            r_host    <= n_host;
            r_stopped <= n_stopped;
        end
    end

endmodule

`default_nettype wire

[sv/kvfe_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module kvfe_queue import kvfe_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_push_entry,
    output logic        o_full,
    input  wire logic   i_pop,
    output logic        o_not_empty,
    output t_entry      o_head
);

    t_entry               r_mem [Q_DEPTH];
    logic [Q_AW-1:0]      r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0]      r_rd_ptr, n_rd_ptr;
    logic [Q_AW:0]        r_count, n_count;

    assign o_full      = (r_count == (Q_AW + 1)'(Q_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_head      = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_not_empty |-> !i_pop)
        else $error("pop from empty queue");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || o_full) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

    a_entry_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (i_push_entry.v0 || i_push_entry.v1))
        else $error("empty entry pushed");

endmodule

`default_nettype wire

[sv/kvfe_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module kvfe_back import kvfe_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_q_not_empty,
    input  wire t_entry i_q_head,
    output logic        o_q_pop,
    output logic        o_out_valid,
    input  wire logic   i_out_ready,
    output t_result     o_out
);

    logic    r_out_valid, n_out_valid;
    t_result r_out, n_out;
    logic    r_hold_valid, n_hold_valid;
    t_result r_hold, n_hold;
    logic    w_load;

    assign w_load      = !r_out_valid || i_out_ready;
    assign o_q_pop     = w_load && !r_hold_valid && i_q_not_empty;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_hold_valid = r_hold_valid;
        n_hold       = r_hold;
        if (w_load) begin
            if (r_hold_valid) begin
                // second result of a byte goes out after the first
                n_out_valid  = 1'b1;
                n_out        = r_hold;
                n_hold_valid = 1'b0;
            end else if (i_q_not_empty) begin
                n_out_valid = 1'b1;
                if (i_q_head.v0) begin
                    n_out        = i_q_head.r0;
                    n_hold_valid = i_q_head.v1;
                    n_hold       = i_q_head.r1;
                end else begin
                    n_out = i_q_head.r1;
                end
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_hold_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_hold_valid <= n_hold_valid;
        end
        r_out  <= n_out;
        r_hold <= n_hold;
    end

endmodule

`default_nettype wire

[sv/key_value_field_extractor.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                   payload
// input     in         i_in_valid / o_in_ready     i_text_byte, i_end_of_file
// result    out        o_out_valid / i_out_ready   o_key_id, o_is_end_marker, o_value_byte,
//                                                  o_value_valid, o_value_length,
//                                                  o_last_of_run
//
// one byte per cycle is taken unless the queue is full; a byte's two results go out in turn
// results leave through a four-entry queue and then an output register
// a result per cycle drains while i_out_ready is high; that port sets the sustained rate
// synchronous active-low reset clears matcher state, the queue and the output register
// o_in_ready drops only while the queue is full

module key_value_field_extractor import kvfe_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_end_of_file,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_key_id,
    output logic            o_is_end_marker,
    output logic [7:0]      o_value_byte,
    output logic            o_value_valid,
    output logic [7:0]      o_value_length,
    output logic            o_last_of_run
);

    logic    w_q_full, w_q_push, w_q_pop, w_q_not_empty;
    t_entry  w_push_entry, w_head;
    t_result w_out;

    kvfe_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_text_byte   (i_text_byte),
        .i_end_of_file (i_end_of_file),
        .i_q_full      (w_q_full),
        .o_q_push      (w_q_push),
        .o_q_entry     (w_push_entry)
    );

    kvfe_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_q_push),
        .i_push_entry (w_push_entry),
        .o_full       (w_q_full),
        .i_pop        (w_q_pop),
        .o_not_empty  (w_q_not_empty),
        .o_head       (w_head)
    );

    kvfe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (w_q_not_empty),
        .i_q_head      (w_head),
        .o_q_pop       (w_q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out         (w_out)
    );

    assign o_key_id        = w_out.key_id;
    assign o_is_end_marker = w_out.is_end_marker;
    assign o_value_byte    = w_out.value_byte;
    assign o_value_valid   = w_out.value_valid;
    assign o_value_length  = w_out.value_length;
    assign o_last_of_run   = w_out.last_of_run;

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
    import kvfe_pkg::*;

    localparam int RUN_LIMIT    = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_CAP    = 30;
    localparam int KEY_COUNT    = 2;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_text_byte = 8'h00;
    logic       i_end_of_file = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic       o_key_id;
    logic       o_is_end_marker;
    logic [7:0] o_value_byte;
    logic       o_value_valid;
    logic [7:0] o_value_length;
    logic       o_last_of_run;

    key_value_field_extractor dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_text_byte    (i_text_byte),
        .i_end_of_file  (i_end_of_file),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_key_id       (o_key_id),
        .o_is_end_marker(o_is_end_marker),
        .o_value_byte   (o_value_byte),
        .o_value_valid  (o_value_valid),
        .o_value_length (o_value_length),
        .o_last_of_run  (o_last_of_run)
    );

    // scanner state, indexed by key
    logic [2:0] match_pos [KEY_COUNT];
    logic       capturing [KEY_COUNT];
    logic [7:0] capture_len [KEY_COUNT];
    logic       nul_seen;

    t_result    field_results [$];
    t_result    oldest_result;
    logic [7:0] file_bytes [$];

    int mismatch_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_left = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic is_stop_char(input logic [7:0] b);
        return (b == CH_NUL) || (b == CH_AMP) || (b == CH_HSH) ||
               (b == CH_CR) || (b == CH_LF) || (b == CH_SP);
    endfunction

    function automatic string key_text(input logic key);
        return (key == KEY_HOST) ? "host=" : "sni=";
    endfunction

    function automatic int key_size(input logic key);
        return (key == KEY_HOST) ? int'(HOST_KEY_LEN) : int'(SNI_KEY_LEN);
    endfunction

    function automatic logic usable_length(input logic [7:0] len);
        return (len >= 8'd1) && (len < LEN_MAX) && (int'(len) < VALUE_BUFFER_LEN - 1);
    endfunction

    function automatic logic [7:0] pick_stop_char();
        logic [7:0] stops [5];
        stops = '{CH_AMP, CH_HSH, CH_CR, CH_LF, CH_SP};
        return stops[$urandom_range(0, 4)];
    endfunction

    // non-terminator byte, often a key letter so matchers get exercised
    function automatic logic [7:0] pick_value_byte();
        string letters;
        logic [7:0] b;
        letters = "snihost=";
        if ($urandom_range(0, 3) == 0) begin
            return letters[$urandom_range(0, 7)];
        end
        b = 8'($urandom_range(0, 255));
        while (is_stop_char(b)) begin
            b = 8'($urandom_range(0, 255));
        end
        return b;
    endfunction

    function automatic void clear_scanner();
        for (int k = 0; k < KEY_COUNT; k++) begin
            match_pos[k]   = 3'd0;
            capturing[k]   = 1'b0;
            capture_len[k] = 8'd0;
        end
        nul_seen = 1'b0;
    endfunction

    task automatic predict_text_byte(input logic [7:0] b, input logic eof);
        t_result found [$];
        t_result r;
        int      p;
        int      klen;
        string   ktext;
        if (!nul_seen) begin
            for (int k = 0; k < KEY_COUNT; k++) begin
                r = '0;
                r.key_id = k[0];
                if (capturing[k]) begin
                    if (is_stop_char(b)) begin
                        r.is_end_marker = 1'b1;
                        r.value_valid   = usable_length(capture_len[k]);
                        r.value_length  = capture_len[k];
                        found.push_back(r);
                        capturing[k]   = 1'b0;
                        capture_len[k] = 8'd0;
                    end else begin
                        if (capture_len[k] != LEN_MAX) begin
                            capture_len[k] = capture_len[k] + 8'd1;
                        end
                        // a value byte on the last byte of the file closes the value itself
                        r.is_end_marker = eof;
                        r.value_byte    = b;
                        r.value_length  = capture_len[k];
                        r.value_valid   = eof ? usable_length(capture_len[k]) : 1'b0;
                        found.push_back(r);
                    end
                end else begin
                    ktext = key_text(k[0]);
                    klen  = key_size(k[0]);
                    p     = int'(match_pos[k]);
                    if (p >= klen) begin
                        p = 0;
                    end
                    if (b == ktext[p]) begin
                        p = p + 1;
                    end else begin
                        p = (b == ktext[0]) ? 1 : 0;
                    end
                    if (p == klen) begin
                        match_pos[k]   = 3'd0;
                        capturing[k]   = 1'b1;
                        capture_len[k] = 8'd0;
                        if (eof) begin
                            r.is_end_marker = 1'b1;
                            found.push_back(r);
                        end
                    end else begin
                        match_pos[k] = 3'(p);
                    end
                end
            end
            if (b == CH_NUL) begin
                clear_scanner();
                nul_seen = 1'b1;
            end
        end
        if (found.size() > 0) begin
            found[found.size() - 1].last_of_run = 1'b1;
        end
        foreach (found[i]) begin
            field_results.push_back(found[i]);
        end
        if (eof) begin
            clear_scanner();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("mismatch at cycle %0d: %s got %0h expected %0h",
                     cycle_count, what, got, want);
        end
    endtask

    // called at a falling edge; returns at the falling edge after acceptance with valid still high
    task automatic send_text_byte(input logic [7:0] b, input logic eof);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_text_byte   <= b;
        i_end_of_file <= eof;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        predict_text_byte(b, eof);
        @(negedge i_clk);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            file_bytes.push_back(s[i]);
        end
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++) begin
            send_text_byte(file_bytes[i], i == file_bytes.size() - 1);
        end
        file_bytes.delete();
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (field_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic build_random_file();
        int    kind;
        int    n;
        logic  key;
        string ktext;
        repeat ($urandom_range(1, 6)) begin
            kind = $urandom_range(0, 19);
            key  = 1'($urandom_range(0, 1));
            if (kind <= 5 || (kind >= 15 && kind <= 17)) begin
                if (kind >= 15) begin
                    add_text("sni=host=");
                end else begin
                    add_text(key_text(key));
                end
                repeat ($urandom_range(0, 10)) file_bytes.push_back(pick_value_byte());
                if ($urandom_range(0, 4) != 0) begin
                    file_bytes.push_back(pick_stop_char());
                end
            end else if (kind <= 8) begin
                repeat ($urandom_range(1, 4)) file_bytes.push_back(8'($urandom_range(0, 255)));
            end else if (kind <= 11) begin
                // broken key: a proper prefix only
                ktext = key_text(key);
                n = $urandom_range(1, key_size(key) - 1);
                add_text(ktext.substr(0, n - 1));
            end else if (kind <= 13) begin
                file_bytes.push_back(pick_stop_char());
            end else if (kind == 14) begin
                file_bytes.push_back(CH_NUL);
            end else begin
                repeat ($urandom_range(1, 6)) file_bytes.push_back(pick_value_byte());
            end
        end
    endtask

    task automatic test_directed();
        // key inside a value, and a final byte that is a value byte for both keys
        add_text("sni=host=");
        file_bytes.push_back(8'hFF);
        send_file();
        // empty value, then a key completed by the final byte
        add_text("host=#sni=");
        send_file();
        // zero byte closes the open value and mutes the rest of the file
        add_text("sni=");
        file_bytes.push_back(8'h01);
        file_bytes.push_back(CH_NUL);
        add_text("z");
        send_file();
        wait_drained();
    endtask

    task automatic test_long_values();
        // host value at the longest usable length while the sni value saturates
        add_text("sni=host=");
        repeat (254) file_bytes.push_back(pick_value_byte());
        file_bytes.push_back(CH_LF);
        send_file();
        wait_drained();
    endtask

    task automatic test_random_files(input int idle_pct, input int stall_pct,
                                     input int byte_target);
        int sent;
        sent           = 0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent < byte_target) begin
            build_random_file();
            sent = sent + file_bytes.size();
            send_file();
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_left  = 120;
        for (int i = 0; i < 4; i++) begin
            add_text("sni=host=");
            repeat (12) file_bytes.push_back(pick_value_byte());
            file_bytes.push_back(CH_AMP);
            send_file();
        end
        wait_drained();
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            hold_off_left = hold_off_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (field_results.size() == 0) begin
                report_mismatch("result with no item waiting", o_value_byte, 8'h00);
            end else begin
                oldest_result = field_results.pop_front();
                if (o_key_id !== oldest_result.key_id)
                    report_mismatch("key_id", o_key_id, oldest_result.key_id);
                if (o_is_end_marker !== oldest_result.is_end_marker)
                    report_mismatch("is_end_marker", o_is_end_marker,
                                    oldest_result.is_end_marker);
                if (o_value_byte !== oldest_result.value_byte)
                    report_mismatch("value_byte", o_value_byte, oldest_result.value_byte);
                if (o_value_valid !== oldest_result.value_valid)
                    report_mismatch("value_valid", o_value_valid, oldest_result.value_valid);
                if (o_value_length !== oldest_result.value_length)
                    report_mismatch("value_length", o_value_length,
                                    oldest_result.value_length);
                if (o_last_of_run !== oldest_result.last_of_run)
                    report_mismatch("last_of_run", o_last_of_run, oldest_result.last_of_run);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count > RUN_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        clear_scanner();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_long_values();
        test_random_files(0, 0, 50);
        test_random_files(47, 0, 50);
        test_random_files(0, 47, 50);
        test_random_files(28, 28, 50);
        test_backpressure();

        if (field_results.size() != 0) begin
            report_mismatch("items still expected at end", 8'(field_results.size()), 8'h00);
        end
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
